FILE: rtl/prpc_pkg.sv
// Shared types and constants for the paired remote packet checker.
`default_nettype none

package prpc_pkg;

    // Command codes carried in the first byte of a packet
    localparam logic [7:0] CMD_SWITCH = 8'd0;
    localparam logic [7:0] CMD_SPEED  = 8'd1;

    // Byte position counter width and saturation value
    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    // Result tdata width: 20 bits of fields, padded to three bytes
    localparam int unsigned RES_W = 24;

    typedef enum logic [1:0] {
        STATUS_APPLIED    = 2'd0,
        STATUS_NO_ACTION  = 2'd1,
        STATUS_NOT_PAIRED = 2'd2,
        STATUS_CSUM_ERR   = 2'd3
    } status_t;

    typedef struct packed {
        logic       save_speed;
        logic [7:0] speed_value;
        logic [7:0] switch_state;
        logic       pair_stored;
        status_t    status;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/paired_remote_packet_checker_top.sv
// Top level of the paired remote packet checker: byte stream in, one result per packet out.
//
// Usage:
//   s_axis carries received radio bytes one request at a time: tdata is the byte,
//   tlast marks the final (XOR checksum) byte, tuser is the pairing-window flag,
//   which only matters on the final byte.
//   m_axis delivers one result request per packet, at the final byte only.
// Datapath: a byte accepted on s_axis is held in the input register; when it
//   advances, the packet state is updated and, for a final byte, the result
//   register is loaded, and the result is offered on m_axis from there.
// Throughput: one byte per cycle while no final byte is held by a stall, set by
//   the single-pass logic between the input register and the result register.
// Reset: asynchronous, active low. Clears the running XOR, the position
//   counter, the command/ID/payload buffers, the paired ID, the switch and
//   speed values and both valid flags. Nothing is offered on m_axis after reset.
// Stall: while a result waits in the output register, non-final bytes keep
//   flowing; a final byte holds in the input register until the result is
//   taken, and s_axis_tready drops only then.
`default_nettype none

module paired_remote_packet_checker_top
    import prpc_pkg::*;
#(
    parameter int unsigned ID_BYTES = 12
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  wire logic             s_axis_tlast,   // last_byte
    input  wire logic             s_axis_tuser,   // pair_open

    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [RES_W-1:0]      m_axis_tdata    // [1:0] status, [2] pair_stored,
                                                  // [10:3] switch_state,
                                                  // [18:11] speed_value,
                                                  // [19] save_speed, [23:20] zero
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_open_reg;

    // Packet state
    logic [7:0]      xor_acc_reg;
    logic [POS_W-1:0] byte_pos_reg;
    logic [7:0]      command_reg;
    logic [7:0]      rx_id_reg  [ID_BYTES];
    logic [7:0]      payload_reg[2];
    logic [7:0]      pair_id_reg[ID_BYTES];
    logic [7:0]      switch_reg;
    logic [7:0]      speed_reg;

    // Output register
    logic    out_valid_reg;
    result_t result_reg;

    logic advance;

    // Buffers with the current byte already written at its position
    logic [7:0] command_next;
    logic [7:0] rx_id_next  [ID_BYTES];
    logic [7:0] payload_next[2];
    logic [7:0] pair_id_next[ID_BYTES];
    logic [7:0] switch_next;
    logic [7:0] speed_next;
    logic       id_match;
    result_t    result_next;

    // A non-final byte never produces a result, so it may move on under a stall
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        command_next = command_reg;
        if (byte_pos_reg == '0)
        begin
            command_next = in_byte_reg;
        end
        for (int i = 0; i < ID_BYTES; i++)
        begin
            rx_id_next[i] = (byte_pos_reg == POS_W'(i + 1)) ? in_byte_reg : rx_id_reg[i];
        end
        for (int j = 0; j < 2; j++)
        begin
            payload_next[j] = (byte_pos_reg == POS_W'(ID_BYTES + 1 + j)) ?
                              in_byte_reg : payload_reg[j];
        end
    end

    always_comb
    begin
        result_next              = '0;
        result_next.switch_state = switch_reg;
        result_next.speed_value  = speed_reg;
        result_next.status       = STATUS_CSUM_ERR;
        switch_next              = switch_reg;
        speed_next               = speed_reg;
        id_match                 = 1'b1;
        for (int i = 0; i < ID_BYTES; i++)
        begin
            pair_id_next[i] = pair_id_reg[i];
        end

        if (xor_acc_reg == in_byte_reg)
        begin
            // Open window: take this remote as the paired one
            if (in_open_reg)
            begin
                for (int i = 0; i < ID_BYTES; i++)
                begin
                    pair_id_next[i] = rx_id_next[i];
                end
                result_next.pair_stored = 1'b1;
            end
            for (int i = 0; i < ID_BYTES; i++)
            begin
                if (pair_id_next[i] != rx_id_next[i])
                begin
                    id_match = 1'b0;
                end
            end
            if (!id_match)
            begin
                result_next.status = STATUS_NOT_PAIRED;
            end
            else if (command_next == CMD_SWITCH)
            begin
                switch_next        = payload_next[0];
                speed_next         = payload_next[1];
                result_next.status = STATUS_APPLIED;
            end
            else if (command_next == CMD_SPEED)
            begin
                speed_next             = payload_next[0];
                result_next.save_speed = 1'b1;
                result_next.status     = STATUS_APPLIED;
            end
            else
            begin
                result_next.status = STATUS_NO_ACTION;
            end
            result_next.switch_state = switch_next;
            result_next.speed_value  = speed_next;
        end
    end

    // Input register: payload needs no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_open_reg <= s_axis_tuser;
        end
    end

    // Packet state update, one byte per advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_acc_reg  <= '0;
            byte_pos_reg <= '0;
            command_reg  <= '0;
            switch_reg   <= '0;
            speed_reg    <= '0;
            for (int i = 0; i < ID_BYTES; i++)
            begin
                rx_id_reg[i]   <= '0;
                pair_id_reg[i] <= '0;
            end
            payload_reg[0] <= '0;
            payload_reg[1] <= '0;
        end
        else if (advance)
        begin
            command_reg <= command_next;
            for (int i = 0; i < ID_BYTES; i++)
            begin
                rx_id_reg[i] <= rx_id_next[i];
            end
            payload_reg[0] <= payload_next[0];
            payload_reg[1] <= payload_next[1];
            if (in_last_reg)
            begin
                xor_acc_reg  <= '0;
                byte_pos_reg <= '0;
                switch_reg   <= switch_next;
                speed_reg    <= speed_next;
                for (int i = 0; i < ID_BYTES; i++)
                begin
                    pair_id_reg[i] <= pair_id_next[i];
                end
            end
            else
            begin
                xor_acc_reg <= xor_acc_reg ^ in_byte_reg;
                if (byte_pos_reg != POS_MAX)
                begin
                    byte_pos_reg <= byte_pos_reg + 1'b1;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(RES_W - $bits(result_t))'(0), result_reg};

endmodule

`default_nettype wire

FILE: bench/paired_remote_packet_checker_top_tb.sv
// Self-checking testbench for the paired remote packet checker top level.
`default_nettype none

module paired_remote_packet_checker_top_tb;
    import prpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ID_LEN = 12;

    typedef logic [7:0] byte_q_t[$];

    // Clock, reset and the two stream groups
    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;   // [7:0] data_byte
    logic             s_axis_tlast;   // last_byte
    logic             s_axis_tuser;   // pair_open
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [RES_W-1:0] m_axis_tdata;   // [1:0] status, [2] pair_stored, [10:3] switch_state,
                                      // [18:11] speed_value, [19] save_speed, [23:20] zero

    // Shadow copy of the packet state, kept in step with every accepted request
    logic [7:0]       run_xor;
    logic [POS_W-1:0] pos_cnt;
    logic [7:0]       cmd_buf;
    logic [7:0]       rx_id [ID_LEN];
    logic [7:0]       payload_buf [2];
    logic [7:0]       pair_id [ID_LEN];
    logic [7:0]       switch_shadow;
    logic [7:0]       speed_shadow;

    // Verdicts of packets whose final byte went in but whose result has not come out yet
    result_t          packet_verdicts_q[$];

    int               send_gap_pct;   // chance per draw that the sender holds off before a request
    int               sink_stall_pct; // chance per cycle that the receiver deasserts tready
    int               bytes_sent;
    int               error_count;

    paired_remote_packet_checker_top #(
        .ID_BYTES (ID_LEN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Receiver: tready changes only on the falling edge
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Update the shadow state for one accepted byte; a final byte yields one verdict.
    task automatic predict_packet_status(input logic [7:0] b, input logic fin,
                                         input logic open);
        result_t verdict;
        logic    id_match;
        // byte lands at its slot (command, ID, payload) before anything else
        if (pos_cnt == 0)
            cmd_buf = b;
        else if (pos_cnt <= ID_LEN)
            rx_id[int'(pos_cnt) - 1] = b;
        else if (pos_cnt <= ID_LEN + 2)
            payload_buf[int'(pos_cnt) - 1 - ID_LEN] = b;
        if (pos_cnt < POS_MAX)
            pos_cnt = pos_cnt + 1'b1;

        if (!fin)
        begin
            run_xor = run_xor ^ b;
            return;
        end

        verdict = '0;
        if (run_xor != b)
        begin
            verdict.status = STATUS_CSUM_ERR;
        end
        else
        begin
            if (open)
            begin
                pair_id = rx_id;
                verdict.pair_stored = 1'b1;
            end
            id_match = 1'b1;
            for (int i = 0; i < ID_LEN; i++)
                if (pair_id[i] != rx_id[i])
                    id_match = 1'b0;
            if (!id_match)
            begin
                verdict.status = STATUS_NOT_PAIRED;
            end
            else if (cmd_buf == CMD_SWITCH)
            begin
                switch_shadow  = payload_buf[0];
                speed_shadow   = payload_buf[1];
                verdict.status = STATUS_APPLIED;
            end
            else if (cmd_buf == CMD_SPEED)
            begin
                speed_shadow       = payload_buf[0];
                verdict.save_speed = 1'b1;
                verdict.status     = STATUS_APPLIED;
            end
            else
            begin
                verdict.status = STATUS_NO_ACTION;
            end
        end
        verdict.switch_state = switch_shadow;
        verdict.speed_value  = speed_shadow;
        packet_verdicts_q.push_back(verdict);
        run_xor = '0;
        pos_cnt = '0;
    endtask

    // Offer one byte request; entered and left on a falling edge, tvalid stays high on exit.
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic open);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        s_axis_tuser  <= open;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_packet_status(b, fin, open);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send a packet body followed by its XOR checksum; a bad checksum is flipped
    // by a nonzero mask. pair_open on body bytes is random since the block ignores it.
    task automatic send_frame(input byte_q_t body, input logic open, input logic bad_sum);
        logic [7:0] csum;
        csum = '0;
        foreach (body[i])
        begin
            csum = csum ^ body[i];
            send_byte(body[i], 1'b0, 1'($urandom_range(1)));
        end
        if (bad_sum)
            csum = csum ^ 8'($urandom_range(255, 1));
        send_byte(csum, 1'b1, open);
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (packet_verdicts_q.size() != 0)
            @(negedge clk);
    endtask

    // Hand-built packets. The pairing ID starts with 01 03 so that the short packets
    // below, whose checksum bytes land in the first ID slots, still match it.
    task automatic test_directed_packets();
        byte_q_t body;
        // full packet, window open: stores the ID, on/off command with extreme payload
        body = '{CMD_SWITCH, 8'h01, 8'h03, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'hAA, 8'h55,
                 8'hFF, 8'h00, 8'h12, 8'h34, 8'hFF, 8'h00};
        send_frame(body, 1'b1, 1'b0);
        // short speed command: checksum 01 lands in ID slot 0, stale payload gives speed
        body = '{CMD_SPEED};
        send_frame(body, 1'b0, 1'b0);
        // single-byte packet: checksum 00 becomes the command, on/off with stale payload
        body = '{};
        send_frame(body, 1'b0, 1'b0);
        // single-byte packet with a nonzero byte: checksum error
        send_frame(body, 1'b0, 1'b1);
        // unknown command, ID slots 0 and 1 still 01 03: no action
        body = '{8'h02, 8'h01};
        send_frame(body, 1'b0, 1'b0);
        // checksum 02 overwrites ID slot 0: remote no longer paired
        body = '{8'h02};
        send_frame(body, 1'b0, 1'b0);
        wait_results_drained();
    endtask

    // Random packet traffic: mostly well-formed packets from the paired remote, plus
    // foreign IDs, re-pairing, short, long (position counter saturation), bad checksums
    // and plain noise.
    task automatic test_random_packets(input int byte_budget);
        byte_q_t    body;
        int         first_byte;
        int         kind;
        int         len;
        logic       open;
        logic       bad_sum;
        logic [7:0] cmd;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < byte_budget)
        begin
            body.delete();
            kind    = $urandom_range(99);
            open    = ($urandom_range(99) < 8);
            bad_sum = ($urandom_range(99) < 6);
            len     = $urandom_range(99);
            cmd     = (len < 45) ? CMD_SWITCH : (len < 85) ? CMD_SPEED : 8'($urandom);
            if (kind < 80)
            begin
                body.push_back(cmd);
                for (int i = 0; i < ID_LEN; i++)
                    body.push_back(($urandom_range(99) < 75) ? pair_id[i] : 8'($urandom));
                body.push_back(8'($urandom));
                body.push_back(8'($urandom));
                // long packet: trailing bytes past the payload, up to past saturation
                if (kind >= 68)
                    repeat ($urandom_range(1, 25))
                        body.push_back(8'($urandom));
            end
            else if (kind < 92)
            begin
                // short packet: stale slots from earlier packets stay in use
                body.push_back(cmd);
                len = $urandom_range(0, ID_LEN + 1);
                for (int i = 0; i < len; i++)
                    body.push_back((i < ID_LEN && $urandom_range(1)) ? pair_id[i]
                                                                     : 8'($urandom));
                if ($urandom_range(3) == 0)
                    body.delete();
            end
            else
            begin
                repeat ($urandom_range(0, 20))
                    body.push_back(8'($urandom));
                open    = 1'($urandom_range(1));
                bad_sum = 1'($urandom_range(1));
            end
            send_frame(body, open, bad_sum);
        end
        wait_results_drained();
    endtask

    // Checker: every accepted result against the oldest outstanding verdict
    task automatic report_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $realtime, field, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[19:0]);
            if (packet_verdicts_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %h",
                         $realtime, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = packet_verdicts_q.pop_front();
                report_field("status", want.status, got.status);
                report_field("pair_stored", want.pair_stored, got.pair_stored);
                report_field("switch_state", want.switch_state, got.switch_state);
                report_field("speed_value", want.speed_value, got.speed_value);
                report_field("save_speed", want.save_speed, got.save_speed);
                report_field("pad bits", 0, m_axis_tdata[RES_W-1:20]);
            end
        end
    end

    // Hard limit, several times the slowest legal run
    initial
    begin
        #2ms;
        $display("[paired_remote_packet_checker_top] ERROR");
        $finish;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        s_axis_tuser   = 1'b0;
        m_axis_tready  = 1'b0;
        run_xor        = '0;
        pos_cnt        = '0;
        cmd_buf        = '0;
        switch_shadow  = '0;
        speed_shadow   = '0;
        payload_buf    = '{default: '0};
        rx_id          = '{default: '0};
        pair_id        = '{default: '0};
        bytes_sent     = 0;
        error_count    = 0;
        send_gap_pct   = 31;
        sink_stall_pct = 72;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase 1: sender idles a little, receiver stalls a lot
        test_directed_packets();
        test_random_packets(680);
        // phase 2: roles swapped
        send_gap_pct   = 72;
        sink_stall_pct = 31;
        test_random_packets(660);
        // phase 3: back to back on both sides
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        test_random_packets(660);

        // leave room for stray results after the queue has drained
        repeat (10) @(posedge clk);
        if (error_count == 0 && packet_verdicts_q.size() == 0)
            $display("[paired_remote_packet_checker_top] OK");
        else
            $display("[paired_remote_packet_checker_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
